FILE: rtl/core/tajt_pkg.sv
// Shared types and constants of the tree ancestor jump table.
package tajt_pkg;

   // Port field widths.
   localparam int NODE_W   = 10;
   localparam int STEPS_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   // Operation codes.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

   // Which result the datapath loads into the response registers.
   typedef enum logic [2:0] {
      RSP_FULL,
      RSP_BAD,
      RSP_NONE,
      RSP_APPENDED,
      RSP_CLIMBED
   } rsp_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         begin_append;
      logic         step_fill;
      logic         begin_query;
      logic         step_climb;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } tajt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic bad_parent;
      logic bad_node;
      logic too_far;
      logic last_level;
   } tajt_stat_type;

endpackage

FILE: rtl/core/tree_ancestor_jump_table.sv
// Top level of the tree ancestor jump table: k-th ancestor lookups on a growing forest.
//
//   Channel   Handshake               Word
//   --------  ----------------------  ------------------------------------------------
//   request   start & !busy           req_op, req_has_parent, req_parent, req_node,
//                                     req_steps
//   response  rsp_strobe, one cycle   rsp_answer_node, rsp_answer_valid, rsp_status,
//                                     rsp_node_count
//
// An append steps through the fill states and then the append end state, and a query
// through the climb states and then the resolve state, before the response strobe; both
// walk the table one level per cycle, each read address coming from the previous read
// of the single table read port. A word that is rejected at once (full store, bad
// index, too many steps) answers in the cycle after acceptance. Busy is low in the
// cycle the response is shown, so the next word may be accepted then. Reset clears
// the node count and the controller; the table itself is not cleared, since only rows
// of stored nodes are ever used. The receiver cannot stall the response.
module tree_ancestor_jump_table
   import tajt_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic                req_has_parent,
   input  logic [NODE_W-1:0]   req_parent,
   input  logic [NODE_W-1:0]   req_node,
   input  logic [STEPS_W-1:0]  req_steps,
   output logic                rsp_strobe,
   output logic [NODE_W-1:0]   rsp_answer_node,
   output logic                rsp_answer_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_node_count
);

   tajt_cmd_type  cmd;
   tajt_stat_type stat;

   // The controller sequences one word at a time: it checks the word on
   // acceptance, then steps the datapath through the levels of the table.
   tajt_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds the node count, the jump table and the response registers.
   tajt_datapath #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_has_parent   (req_has_parent),
      .req_parent       (req_parent),
      .req_node         (req_node),
      .req_steps        (req_steps),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_answer_node  (rsp_answer_node),
      .rsp_answer_valid (rsp_answer_valid),
      .rsp_status       (rsp_status),
      .rsp_node_count   (rsp_node_count)
   );

endmodule

FILE: rtl/core/tajt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tajt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tajt_ctrl.sv
// Controller state machine of the tree ancestor jump table.
module tajt_ctrl
   import tajt_pkg::*;
#(
   parameter int LEVELS = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          op,
   input  tajt_stat_type stat,
   output logic          busy,
   output tajt_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_FILL       = 5'b00010,
      S_APPEND_END = 5'b00100,
      S_CLIMB      = 5'b01000,
      S_RESOLVE    = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_kind = RSP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (op == OP_APPEND) begin
                  if (stat.full) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RSP_FULL;
                  end else if (stat.bad_parent) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RSP_BAD;
                  end else begin
                     cmd.begin_append = 1'b1;
                     state_in = (LEVELS > 1) ? S_FILL : S_APPEND_END;
                  end
               end else begin
                  if (stat.bad_node) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RSP_BAD;
                  end else if (stat.too_far) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RSP_NONE;
                  end else begin
                     cmd.begin_query = 1'b1;
                     state_in = S_CLIMB;
                  end
               end
            end
         end
         S_FILL: begin
            cmd.step_fill = 1'b1;
            if (stat.last_level) begin
               state_in = S_APPEND_END;
            end
         end
         S_APPEND_END: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = RSP_APPENDED;
            state_in = S_IDLE;
         end
         S_CLIMB: begin
            cmd.step_climb = 1'b1;
            if (stat.last_level) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = RSP_CLIMBED;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/core/tajt_datapath.sv
// Datapath of the tree ancestor jump table: node count, jump table and result registers.
module tajt_datapath
   import tajt_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_has_parent,
   input  logic [NODE_W-1:0]   req_parent,
   input  logic [NODE_W-1:0]   req_node,
   input  logic [STEPS_W-1:0]  req_steps,
   input  tajt_cmd_type        cmd,
   output tajt_stat_type       stat,
   output logic                rsp_strobe,
   output logic [NODE_W-1:0]   rsp_answer_node,
   output logic                rsp_answer_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_node_count
);

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ENT_W  = IDX_W + 1;
   localparam int ADDR_W = IDX_W + LVL_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int CMP_W  = (CNT_W > NODE_W) ? CNT_W : NODE_W;

   // A table entry holds an ancestor index under a valid bit at the top.
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  cur_ff;
   logic [ENT_W-1:0]  up_ff;
   logic [ENT_W-1:0]  at_ff;
   logic              took_ff;
   logic [LVL_W-1:0]  lvl_ff;
   logic [LEVELS-1:0] steps_ff;

   logic [ENT_W-1:0]  fill_nx;
   logic [ENT_W-1:0]  pos;
   logic [ENT_W-1:0]  root_entry;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENT_W-1:0]  rd_data;

   logic                rsp_strobe_ff;
   logic [NODE_W-1:0]   rsp_answer_node_ff;
   logic                rsp_answer_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_node_count_ff;

   assign stat.full       = (count_ff == CNT_W'(MAX_NODES));
   assign stat.bad_parent = req_has_parent && (CMP_W'(req_parent) >= CMP_W'(count_ff));
   assign stat.bad_node   = (CMP_W'(req_node) >= CMP_W'(count_ff));
   assign stat.too_far    = ((req_steps >> LEVELS) != '0);
   assign stat.last_level = (lvl_ff == LVL_W'(LEVELS - 1));

   // Level zero entry of a new node; a root has no ancestor.
   assign root_entry = req_has_parent ? {1'b1, IDX_W'(req_parent)} : '0;

   // The previous cycle read the next ancestor when the current one exists.
   assign fill_nx = up_ff[IDX_W] ? rd_data : '0;
   assign pos     = took_ff ? rd_data : at_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {IDX_W'(count_ff), LVL_W'(0)};
      wr_data = root_entry;
      rd_addr = {pos[IDX_W-1:0], lvl_ff};
      priority if (cmd.begin_append) begin
         wr_en   = 1'b1;
         rd_addr = {IDX_W'(req_parent), LVL_W'(0)};
      end else if (cmd.step_fill) begin
         wr_en   = 1'b1;
         wr_addr = {cur_ff, lvl_ff};
         wr_data = fill_nx;
         rd_addr = {fill_nx[IDX_W-1:0], lvl_ff};
      end else begin
         rd_addr = {pos[IDX_W-1:0], lvl_ff};
      end
   end

   tajt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.begin_append) begin
         cur_ff <= IDX_W'(count_ff);
         up_ff  <= root_entry;
         lvl_ff <= LVL_W'(1);
      end else if (cmd.step_fill) begin
         up_ff  <= fill_nx;
         lvl_ff <= lvl_ff + LVL_W'(1);
      end else if (cmd.begin_query) begin
         at_ff    <= {1'b1, IDX_W'(req_node)};
         took_ff  <= 1'b0;
         lvl_ff   <= LVL_W'(0);
         steps_ff <= LEVELS'(req_steps);
      end else if (cmd.step_climb) begin
         at_ff   <= pos;
         took_ff <= steps_ff[lvl_ff] && pos[IDX_W];
         lvl_ff  <= lvl_ff + LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load;
         if (cmd.rsp_load && (cmd.rsp_kind == RSP_APPENDED)) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_answer_node_ff  <= '0;
         rsp_answer_valid_ff <= 1'b0;
         rsp_status_ff       <= ST_OK;
         rsp_node_count_ff   <= COUNT_W'(count_ff);
         unique case (cmd.rsp_kind)
            RSP_FULL: begin
               rsp_status_ff <= ST_FULL;
            end
            RSP_BAD: begin
               rsp_status_ff <= ST_BAD_INDEX;
            end
            RSP_NONE: begin
               rsp_status_ff <= ST_OK;
            end
            RSP_APPENDED: begin
               rsp_answer_node_ff  <= NODE_W'(cur_ff);
               rsp_answer_valid_ff <= 1'b1;
               rsp_node_count_ff   <= COUNT_W'(count_ff + CNT_W'(1));
            end
            RSP_CLIMBED: begin
               rsp_answer_node_ff  <= pos[IDX_W] ? NODE_W'(pos[IDX_W-1:0]) : '0;
               rsp_answer_valid_ff <= pos[IDX_W];
            end
            default: begin
               rsp_status_ff <= ST_OK;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_answer_node  = rsp_answer_node_ff;
   assign rsp_answer_valid = rsp_answer_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_node_count   = rsp_node_count_ff;

endmodule

FILE: rtl/core/tajt_checker.sv
// Port-level checks of the tree ancestor jump table and their bind.
module tajt_checker
   import tajt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [NODE_W-1:0]   rsp_answer_node,
   input logic                rsp_answer_valid,
   input logic [STATUS_W-1:0] rsp_status
);

   // An accepted word either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted word neither answered nor started work");

   // A response is shown only once the block is ready for the next word.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while still busy");

   // A valid answer never carries an error status.
   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_answer_valid) |-> (rsp_status == ST_OK))
      else $error("valid answer with error status");

   // Without an answer the node field reads zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_answer_valid) |-> (rsp_answer_node == '0))
      else $error("invalid answer with nonzero node");

endmodule

bind tree_ancestor_jump_table tajt_checker u_tajt_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_answer_node  (rsp_answer_node),
   .rsp_answer_valid (rsp_answer_valid),
   .rsp_status       (rsp_status)
);

FILE: dv/tb_top.sv
// Testbench for the tree ancestor jump table: directed and random appends and ancestor queries.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tajt_pkg::*;

   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 10;

   // The limit is many times over the slowest correct word plus the longest
   // idle gap that the sender inserts.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles to keep watching after the last expected response has arrived,
   // so that a stray extra strobe is still caught.
   localparam int DRAIN_CYCLES = LEVELS + 10;

   // One response word as the block presents it.
   typedef struct {
      logic [NODE_W-1:0]   node;
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = OP_APPEND;
   logic                req_has_parent = 1'b0;
   logic [NODE_W-1:0]   req_parent = '0;
   logic [NODE_W-1:0]   req_node = '0;
   logic [STEPS_W-1:0]  req_steps = '0;
   logic                rsp_strobe;
   logic [NODE_W-1:0]   rsp_answer_node;
   logic                rsp_answer_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_node_count;

   tree_ancestor_jump_table #(
      .MAX_NODES(MAX_NODES),
      .LEVELS   (LEVELS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_has_parent  (req_has_parent),
      .req_parent      (req_parent),
      .req_node        (req_node),
      .req_steps       (req_steps),
      .rsp_strobe      (rsp_strobe),
      .rsp_answer_node (rsp_answer_node),
      .rsp_answer_valid(rsp_answer_valid),
      .rsp_status      (rsp_status),
      .rsp_node_count  (rsp_node_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state. The testbench keeps its own lifting table: for every
   // stored node and every level h, the 2^h-th ancestor and whether it
   // exists. The depth of each node is kept as well, purely to steer the
   // stimulus toward climbs that end right at a root or just past it.
   // ------------------------------------------------------------------
   logic [NODE_W-1:0] lift_node [MAX_NODES][LEVELS];
   logic              lift_ok   [MAX_NODES][LEVELS];
   int                depth_of  [MAX_NODES];
   int                nodes_held = 0;

   // Responses that the block still owes, oldest first.
   answer_type pending_answers[$];

   int fail_count = 0;
   int stall_cycles = 0;
   bit gapless = 1'b0;

   // Works out the response to one accepted word and updates the predicted
   // table and node count exactly as the block should.
   function automatic answer_type apply_word(input logic op, input logic has_parent,
                                             input logic [NODE_W-1:0] parent,
                                             input logic [NODE_W-1:0] node,
                                             input logic [STEPS_W-1:0] steps);
      answer_type        a;
      logic [NODE_W-1:0] up;
      logic              up_ok;
      logic [NODE_W-1:0] at;
      logic              ok;
      int                h;
      a.node   = '0;
      a.valid  = 1'b0;
      a.status = ST_OK;
      if (op == OP_APPEND) begin
         // A full store is reported ahead of a bad parent.
         if (nodes_held >= MAX_NODES) begin
            a.status = ST_FULL;
         end else if (has_parent && parent >= nodes_held) begin
            a.status = ST_BAD_INDEX;
         end else begin
            // Level 0 is the parent itself; level h+1 is the level-h entry
            // of the level-h ancestor. A root has no ancestor at any level.
            up    = has_parent ? parent : '0;
            up_ok = has_parent;
            for (h = 0; h < LEVELS; h++) begin
               lift_node[nodes_held][h] = up;
               lift_ok[nodes_held][h]   = up_ok;
               if (up_ok) begin
                  at    = lift_node[up][h];
                  up_ok = lift_ok[up][h];
                  up    = at;
               end
            end
            depth_of[nodes_held] = has_parent ? depth_of[parent] + 1 : 0;
            a.node  = nodes_held[NODE_W-1:0];
            a.valid = 1'b1;
            nodes_held++;
         end
      end else begin
         if (node >= nodes_held) begin
            a.status = ST_BAD_INDEX;
         end else if (steps >= (1 << LEVELS)) begin
            // Beyond the reach of the table: no ancestor, but not an error.
            a.status = ST_OK;
         end else begin
            // One table hop per set bit of the step count, low bit first.
            at = node;
            ok = 1'b1;
            for (h = 0; h < LEVELS && ok; h++) begin
               if (steps[h]) begin
                  ok = lift_ok[at][h];
                  at = lift_node[at][h];
               end
            end
            a.valid = ok;
            a.node  = ok ? at : '0;
         end
      end
      a.count = nodes_held[COUNT_W-1:0];
      return a;
   endfunction

   // ------------------------------------------------------------------
   // Response checker. The receiver cannot stall, so every strobe is a
   // word that must match the oldest prediction, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            $error("response word with nothing expected: node %0d valid %0d status %0d count %0d",
                   rsp_answer_node, rsp_answer_valid, rsp_status, rsp_node_count);
            fail_count++;
         end else begin
            due = pending_answers.pop_front();
            if (rsp_answer_node !== due.node) begin
               $error("answer_node: expected %0d, actual %0d", due.node, rsp_answer_node);
               fail_count++;
            end
            if (rsp_answer_valid !== due.valid) begin
               $error("answer_valid: expected %0d, actual %0d", due.valid, rsp_answer_valid);
               fail_count++;
            end
            if (rsp_status !== due.status) begin
               $error("status: expected %0d, actual %0d", due.status, rsp_status);
               fail_count++;
            end
            if (rsp_node_count !== due.count) begin
               $error("node_count: expected %0d, actual %0d", due.count, rsp_node_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: any accepted request or response word resets the count of
   // quiet cycles; a hung handshake ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Presents one request word and holds it until the block takes it. It is
   // called right after a rising edge and returns right after the accepting
   // edge, with start still high so that a back-to-back word needs no toggle.
   task automatic send_word(input logic op, input logic has_parent,
                            input logic [NODE_W-1:0] parent,
                            input logic [NODE_W-1:0] node,
                            input logic [STEPS_W-1:0] steps);
      start          <= 1'b1;
      req_op         <= op;
      req_has_parent <= has_parent;
      req_parent     <= parent;
      req_node       <= node;
      req_steps      <= steps;
      do @(posedge clock); while (busy);
      pending_answers = {pending_answers, apply_word(op, has_parent, parent, node, steps)};
   endtask

   // Drops start for a random number of cycles. Mostly nothing or a few
   // cycles, which lands the next word on every phase of the level walk,
   // and now and then a long pause that lets the block fall fully idle.
   task automatic idle_after_word();
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (gapless || r < 50) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 4);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic append_node(input logic has_parent, input logic [NODE_W-1:0] parent);
      send_word(OP_APPEND, has_parent, parent, NODE_W'($urandom), STEPS_W'($urandom));
      idle_after_word();
   endtask

   task automatic query_node(input logic [NODE_W-1:0] node, input logic [STEPS_W-1:0] steps);
      send_word(OP_QUERY, 1'($urandom), NODE_W'($urandom), node, steps);
      idle_after_word();
   endtask

   // Mostly extends the newest node, so that chains get deep enough to use
   // the high levels of the table, with some bushy and scattered branching.
   function automatic logic [NODE_W-1:0] pick_parent();
      int r;
      int low;
      r = $urandom_range(0, 99);
      low = (nodes_held > 8) ? nodes_held - 8 : 0;
      if (r < 50) return NODE_W'(nodes_held - 1);
      if (r < 75) return NODE_W'($urandom_range(low, nodes_held - 1));
      return NODE_W'($urandom_range(0, nodes_held - 1));
   endfunction

   // Step counts cluster around the node's depth, so that climbs end right
   // at a root, one step past it, or somewhere inside the path.
   function automatic logic [STEPS_W-1:0] pick_steps(input logic [NODE_W-1:0] node);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return STEPS_W'($urandom_range(0, depth_of[node] + 1));
      if (r < 75) return STEPS_W'($urandom_range(0, (1 << LEVELS) - 1));
      if (r < 85) return STEPS_W'(1 << $urandom_range(0, STEPS_W - 1));
      return STEPS_W'($urandom_range(0, (1 << STEPS_W) - 1));
   endfunction

   task automatic query_stored_node();
      logic [NODE_W-1:0] nd;
      if ($urandom_range(0, 4) == 0) nd = NODE_W'(nodes_held - 1);
      else nd = NODE_W'($urandom_range(0, nodes_held - 1));
      query_node(nd, pick_steps(nd));
   endtask

   // Hand-picked words on a tiny forest: the empty store, roots with a
   // garbage parent field, a short chain, bad parents, bad query nodes,
   // zero steps, a climb that ends exactly at a root, one past it, and
   // step counts at and beyond the reach of the table.
   task automatic test_directed();
      query_node(10'd0, 16'd0);          // nothing stored yet
      append_node(1'b1, 10'd0);          // parent not yet stored
      append_node(1'b0, 10'h3FF);        // root 0, parent field ignored
      append_node(1'b1, 10'd0);          // node 1
      append_node(1'b1, 10'd1);          // node 2
      append_node(1'b1, 10'd2);          // node 3
      append_node(1'b0, 10'h155);        // root 4
      append_node(1'b1, 10'd5);          // parent equal to the count
      append_node(1'b1, 10'h3FF);        // parent far out of range
      query_node(10'd3, 16'd0);
      query_node(10'd3, 16'd1);
      query_node(10'd3, 16'd2);
      query_node(10'd3, 16'd3);          // lands on the root
      query_node(10'd3, 16'd4);          // one step past the root
      query_node(10'd4, 16'd1);          // a root has no parent
      query_node(10'd4, 16'd0);
      query_node(10'd5, 16'd0);          // node equal to the count
      query_node(10'h3FF, 16'd1);
      query_node(10'd3, 16'd1023);
      query_node(10'd3, 16'd1024);       // just beyond the table
      query_node(10'd3, 16'hFFFF);
      query_node(10'd2, 16'h8001);
   endtask

   // The bulk of the run: well-formed appends and queries with random
   // content, plus a tenth of fully random words that hit the error paths.
   // Every sixty words the sender decides whether to idle at all.
   task automatic test_random_forest(input int words);
      int n;
      int r;
      for (n = 0; n < words; n++) begin
         if (n % 60 == 0) gapless = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 45) begin
            if (nodes_held == 0 || $urandom_range(0, 99) < 6) append_node(1'b0, NODE_W'($urandom));
            else append_node(1'b1, pick_parent());
         end else if (r < 90 && nodes_held > 0) begin
            query_stored_node();
         end else begin
            send_word(1'($urandom), 1'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                      STEPS_W'($urandom));
            idle_after_word();
         end
      end
      gapless = 1'b0;
   endtask

   // Fills the store to the last index, mostly as one long chain so that
   // the deepest climbs use every level, then checks that a full store
   // rejects appends of roots and of children alike and still answers
   // queries, up to the highest node index.
   task automatic test_full_store();
      int n;
      while (nodes_held < MAX_NODES) begin
         if ($urandom_range(0, 9) == 0) append_node(1'b1, pick_parent());
         else append_node(1'b1, NODE_W'(nodes_held - 1));
      end
      append_node(1'b0, 10'd0);
      append_node(1'b1, 10'd7);
      append_node(1'b1, 10'h3FF);
      query_node(10'h3FF, 16'd0);
      query_node(10'h3FF, STEPS_W'(depth_of[MAX_NODES - 1]));
      query_node(10'h3FF, STEPS_W'(depth_of[MAX_NODES - 1] + 1));
      query_node(10'h3FF, 16'd1023);
      for (n = 0; n < 40; n++) query_stored_node();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_forest(800);
      test_full_store();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
